@@ src/hlc_pkg.sv @@
// Shared segment classes for the homogeneous line clipper.
package hlc_pkg;

    typedef logic [1:0] seg_kind_t;

    localparam seg_kind_t KIND_ACCEPT = 2'd0;
    localparam seg_kind_t KIND_REJECT = 2'd1;
    localparam seg_kind_t KIND_CLIP   = 2'd2;

    localparam int N_PLANES = 6;
    localparam int N_COORDS = 8;
    localparam int OC_WIDTH = 6;

    // handshake between two internal stages
    typedef struct packed {
        logic valid;
    } hs_t;

endpackage

@@ src/hlc_front.sv @@
// Front stage: registers a segment, classifies it and forms the plane terms.
module hlc_front #(
    parameter int COORD_WIDTH = 32,
    parameter int DATA_WIDTH  = 8 * 32 + 12 * 34 + 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hlc_pkg::N_COORDS*COORD_WIDTH-1:0] in_coords,
    input  logic [hlc_pkg::OC_WIDTH-1:0]  in_start_oc,
    input  logic [hlc_pkg::OC_WIDTH-1:0]  in_end_oc,
    output hlc_pkg::hs_t                  push_hs_o,
    input  logic                          push_ready,
    output logic [DATA_WIDTH-1:0]         push_data
);
    localparam int W  = COORD_WIDTH;
    localparam int NW = COORD_WIDTH + 2;
    localparam int CB = hlc_pkg::N_COORDS * W;

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    hlc_pkg::seg_kind_t    kind;

    function automatic logic signed [NW-1:0] sx(input logic [W-1:0] v);
        sx = $signed({{2{v[W-1]}}, v});
    endfunction

    always_comb begin
        logic signed [NW-1:0] sa, sw, da, dw;
        if ((in_start_oc | in_end_oc) == '0) begin
            kind = hlc_pkg::KIND_ACCEPT;
        end else if ((in_start_oc & in_end_oc) != '0) begin
            kind = hlc_pkg::KIND_REJECT;
        end else begin
            kind = hlc_pkg::KIND_CLIP;
        end
        data_next = '0;
        data_next[CB-1:0] = in_coords;
        dw = sx(in_coords[7*W +: W]) - sx(in_coords[3*W +: W]);
        sw = sx(in_coords[3*W +: W]);
        for (int ax = 0; ax < 3; ax++) begin
            sa = sx(in_coords[ax*W +: W]);
            da = sx(in_coords[(4+ax)*W +: W]) - sa;
            data_next[CB + (2*ax)*NW +: NW]       = -sa - sw;
            data_next[CB + (2*ax+1)*NW +: NW]     = sa - sw;
            data_next[CB + (6+2*ax)*NW +: NW]     = da + dw;
            data_next[CB + (6+2*ax+1)*NW +: NW]   = dw - da;
        end
        data_next[DATA_WIDTH-1 -: 2] = kind;
    end

    assign in_ready        = !valid_reg || push_ready;
    assign push_hs_o.valid = valid_reg;
    assign push_data       = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (push_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end
endmodule

@@ src/hlc_queue.sv @@
// Two-entry queue between front and back stages.
module hlc_queue #(
    parameter int DATA_WIDTH = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hlc_pkg::hs_t          push_hs_i,
    output logic                  push_ready,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output logic [DATA_WIDTH-1:0] pop_data
);
    localparam int DEPTH = 2;

    logic [DATA_WIDTH-1:0] mem_reg [DEPTH];
    logic                  wptr_reg, rptr_reg;
    logic [1:0]            count_reg;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rptr_reg];
    assign do_push    = push_hs_i.valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (do_push) wptr_reg <= ~wptr_reg;
            if (do_pop)  rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end
endmodule

@@ src/hlc_back.sv @@
// Back stage: plane-by-plane parametric clip, interpolation and result register.
module hlc_back #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16,
    parameter int DATA_WIDTH  = 8 * 32 + 12 * 34 + 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [DATA_WIDTH-1:0]   in_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_visible,
    output logic                    m_unclipped,
    output logic [T_FRAC_BITS:0]    m_enter_t,
    output logic [T_FRAC_BITS:0]    m_exit_t,
    output logic [hlc_pkg::N_COORDS*COORD_WIDTH-1:0] m_coords
);
    localparam int W   = COORD_WIDTH;
    localparam int F   = T_FRAC_BITS;
    localparam int NW  = COORD_WIDTH + 2;
    localparam int TW  = T_FRAC_BITS + 3;
    localparam int TU  = T_FRAC_BITS + 1;
    localparam int PW  = COORD_WIDTH + 1 + TU;
    localparam int CB  = hlc_pkg::N_COORDS * W;
    localparam int CW  = $clog2(T_FRAC_BITS + 1);
    localparam logic [TU-1:0] T_ONE = TU'(1) << F;
    localparam logic [PW-1:0] HALF  = PW'(1) << (F - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_LERP  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]              state_reg;
    logic [2:0]              plane_reg;
    logic [CW-1:0]           step_reg;
    logic [3:0]              lcnt_reg;
    logic signed [NW-1:0]    den_sh [hlc_pkg::N_PLANES];
    logic signed [NW-1:0]    num_sh [hlc_pkg::N_PLANES];
    logic [W-1:0]            s_sh [4];
    logic [W-1:0]            e_sh [4];
    logic [W-1:0]            res_sh [hlc_pkg::N_COORDS];
    logic [NW:0]             rem_reg;
    logic [NW-1:0]           dvs_reg;
    logic [TU-1:0]           q_reg;
    logic                    neg_reg, sat_reg;
    logic signed [TW-1:0]    tin_reg, tout_reg;
    logic [PW-1:0]           prod_reg;
    logic [W-1:0]            a_reg;
    logic                    dneg_reg;
    logic                    res_vis_reg, res_uncl_reg;
    logic [TU-1:0]           res_tin_reg, res_tout_reg;
    logic                    m_valid_reg, m_visible_reg, m_unclipped_reg;
    logic [TU-1:0]           m_enter_reg, m_exit_reg;
    logic [CB-1:0]           m_coords_reg;

    // plane terms at the head of the shift line
    logic [NW-1:0]           n_mag, d_mag;
    logic [NW:0]             rs;
    logic                    ge;
    logic signed [TW-1:0]    t_plane;
    logic [TU-1:0]           tin_c, tout_c;
    logic signed [W:0]       dl;
    logic [W:0]              dl_mag;
    logic [PW-1:0]           lmag;
    logic                    out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        logic [TW-1:0] mag;
        n_mag = num_sh[0][NW-1] ? NW'(-num_sh[0]) : NW'(num_sh[0]);
        d_mag = den_sh[0][NW-1] ? NW'(-den_sh[0]) : NW'(den_sh[0]);
        rs    = (step_reg == '0) ? rem_reg : {rem_reg[NW-1:0], 1'b0};
        ge    = (rs >= {1'b0, dvs_reg});
        mag   = sat_reg ? (TW'(1) << (F + 1)) : TW'(q_reg);
        t_plane = neg_reg ? $signed(-mag - TW'(rem_reg != '0 && !sat_reg)) : $signed(mag);
        tin_c  = tin_reg[TW-1] ? '0 : tin_reg[TU-1:0];
        tout_c = (tout_reg > $signed(TW'(T_ONE))) ? T_ONE : tout_reg[TU-1:0];
        dl     = $signed({e_sh[0][W-1], e_sh[0]}) - $signed({s_sh[0][W-1], s_sh[0]});
        dl_mag = dl[W] ? (W+1)'(-dl) : (W+1)'(dl);
        lmag   = (prod_reg + HALF) >> F;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        case (in_data[DATA_WIDTH-1 -: 2])
                            hlc_pkg::KIND_ACCEPT: state_reg <= ST_DONE;
                            hlc_pkg::KIND_CLIP:   state_reg <= ST_SETUP;
                            default:              state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_SETUP: begin
                    if (den_sh[0] == '0) begin
                        if (!num_sh[0][NW-1] && num_sh[0] != '0) begin
                            state_reg <= ST_DONE;
                        end else if (plane_reg == 3'(hlc_pkg::N_PLANES - 1)) begin
                            state_reg <= ST_LERP;
                        end else begin
                            state_reg <= ST_SETUP;
                        end
                    end else if ({1'b0, n_mag} >= {d_mag, 1'b0}) begin
                        state_reg <= ST_UPD;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (step_reg == CW'(F)) state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    if (den_sh[0] != '0 &&
                        ((!den_sh[0][NW-1] && t_plane > tout_reg) ||
                         (den_sh[0][NW-1] && t_plane < tin_reg))) begin
                        state_reg <= ST_DONE;
                    end else if (plane_reg == 3'(hlc_pkg::N_PLANES - 1)) begin
                        state_reg <= ST_LERP;
                    end else begin
                        state_reg <= ST_SETUP;
                    end
                end
                ST_LERP: begin
                    if (lcnt_reg == 4'd8) state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                for (int k = 0; k < hlc_pkg::N_PLANES; k++) begin
                    num_sh[k] <= $signed(in_data[CB + k*NW +: NW]);
                    den_sh[k] <= $signed(in_data[CB + (6+k)*NW +: NW]);
                end
                for (int k = 0; k < 4; k++) begin
                    s_sh[k] <= in_data[k*W +: W];
                    e_sh[k] <= in_data[(4+k)*W +: W];
                end
                plane_reg <= '0;
                tin_reg   <= '0;
                tout_reg  <= $signed(TW'(T_ONE));
                res_tin_reg <= '0;
                if (in_data[DATA_WIDTH-1 -: 2] == hlc_pkg::KIND_ACCEPT) begin
                    res_vis_reg  <= 1'b1;
                    res_uncl_reg <= 1'b1;
                    res_tout_reg <= T_ONE;
                    for (int k = 0; k < hlc_pkg::N_COORDS; k++) begin
                        res_sh[k] <= in_data[k*W +: W];
                    end
                end else begin
                    res_vis_reg  <= 1'b0;
                    res_uncl_reg <= 1'b0;
                    res_tout_reg <= '0;
                    for (int k = 0; k < hlc_pkg::N_COORDS; k++) res_sh[k] <= '0;
                end
            end
            ST_SETUP: begin
                rem_reg  <= {1'b0, n_mag};
                dvs_reg  <= d_mag;
                q_reg    <= '0;
                step_reg <= '0;
                neg_reg  <= num_sh[0][NW-1] ^ den_sh[0][NW-1];
                sat_reg  <= ({1'b0, n_mag} >= {d_mag, 1'b0});
                lcnt_reg <= '0;
                // parallel plane that keeps the segment: advance to the next plane
                if (den_sh[0] == '0 && (num_sh[0][NW-1] || num_sh[0] == '0)) begin
                    for (int k = 0; k < hlc_pkg::N_PLANES - 1; k++) begin
                        den_sh[k] <= den_sh[k+1];
                        num_sh[k] <= num_sh[k+1];
                    end
                    plane_reg <= plane_reg + 3'd1;
                end
            end
            ST_DIV: begin
                rem_reg  <= ge ? (rs - {1'b0, dvs_reg}) : rs;
                q_reg    <= {q_reg[TU-2:0], ge};
                step_reg <= step_reg + CW'(1);
            end
            ST_UPD: begin
                lcnt_reg <= '0;
                if (den_sh[0] != '0) begin
                    if (!den_sh[0][NW-1]) begin
                        if (t_plane > tin_reg) tin_reg <= t_plane;
                    end else begin
                        if (t_plane < tout_reg) tout_reg <= t_plane;
                    end
                    for (int k = 0; k < hlc_pkg::N_PLANES - 1; k++) begin
                        den_sh[k] <= den_sh[k+1];
                        num_sh[k] <= num_sh[k+1];
                    end
                    plane_reg <= plane_reg + 3'd1;
                end
            end
            ST_LERP: begin
                if (lcnt_reg < 4'd8) begin
                    prod_reg <= PW'(dl_mag) * PW'(lcnt_reg < 4'd4 ? tin_c : tout_c);
                    a_reg    <= s_sh[0];
                    dneg_reg <= dl[W];
                    for (int k = 0; k < 3; k++) begin
                        s_sh[k] <= s_sh[k+1];
                        e_sh[k] <= e_sh[k+1];
                    end
                    s_sh[3] <= s_sh[0];
                    e_sh[3] <= e_sh[0];
                end
                if (lcnt_reg != 4'd0) begin
                    for (int k = 0; k < hlc_pkg::N_COORDS - 1; k++) res_sh[k] <= res_sh[k+1];
                    res_sh[7] <= dneg_reg ? (a_reg - lmag[W-1:0]) : (a_reg + lmag[W-1:0]);
                end
                lcnt_reg     <= lcnt_reg + 4'd1;
                res_vis_reg  <= 1'b1;
                res_uncl_reg <= 1'b0;
                res_tin_reg  <= tin_c;
                res_tout_reg <= tout_c;
            end
            default: begin
            end
        endcase
        if (state_reg == ST_DONE && out_free) begin
            m_visible_reg   <= res_vis_reg;
            m_unclipped_reg <= res_uncl_reg;
            m_enter_reg     <= res_tin_reg;
            m_exit_reg      <= res_tout_reg;
            for (int k = 0; k < hlc_pkg::N_COORDS; k++) m_coords_reg[k*W +: W] <= res_sh[k];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_visible   = m_visible_reg;
    assign m_unclipped = m_unclipped_reg;
    assign m_enter_t   = m_enter_reg;
    assign m_exit_t    = m_exit_reg;
    assign m_coords    = m_coords_reg;

`ifndef SYNTH
    a_uncl_vis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_unclipped_reg |-> m_visible_reg)
        else $error("unclipped result not marked visible");
    a_rej_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_visible_reg |-> m_enter_reg == '0 && m_exit_reg == '0)
        else $error("rejected result carries parameters");
    a_t_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_visible_reg |-> m_enter_reg <= m_exit_reg && m_exit_reg <= T_ONE)
        else $error("enter parameter beyond exit parameter");
`endif
endmodule

@@ src/homogeneous_line_clipper_unit.sv @@
// Top level of the homogeneous line clipper.
//
// Usage: a segment (two clip-space vertices in signed Q16.16 plus a 6-bit
// outside code per vertex) is offered on the s_ channel and transfers when
// s_valid and s_ready are both high. One result transfers per segment on the
// m_ channel, in order, under m_valid / m_ready.
// The front stage registers and classifies each segment (trivial accept,
// trivial reject, clip) and forms the six plane numerators and denominators.
// A two-entry queue decouples it from the back stage, which walks the planes
// with one shared restoring divider, one quotient bit per cycle.
// Back stage: accepted or rejected segments go straight to the result; a
// clipped segment walks the planes through the divider loop and is then
// interpolated through one shared multiplier. The back stage takes a new
// segment only when it is idle; the front register and the queue lie before it.
// The result sits in an output register, so the back stage already works on
// the next segment while the receiver stalls; s_ready drops once the queue is full and
// the front register holds a segment. Reset (aresetn low, synchronous) empties the front
// register, the queue and the output register; no state survives between segments.
module homogeneous_line_clipper_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_start_x,
    input  logic signed [COORD_WIDTH-1:0] s_start_y,
    input  logic signed [COORD_WIDTH-1:0] s_start_z,
    input  logic signed [COORD_WIDTH-1:0] s_start_w,
    input  logic signed [COORD_WIDTH-1:0] s_end_x,
    input  logic signed [COORD_WIDTH-1:0] s_end_y,
    input  logic signed [COORD_WIDTH-1:0] s_end_z,
    input  logic signed [COORD_WIDTH-1:0] s_end_w,
    input  logic [5:0]                    s_start_outcode,
    input  logic [5:0]                    s_end_outcode,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_visible,
    output logic                          m_unclipped,
    output logic [T_FRAC_BITS:0]          m_enter_t,
    output logic [T_FRAC_BITS:0]          m_exit_t,
    output logic signed [COORD_WIDTH-1:0] m_clip_start_x,
    output logic signed [COORD_WIDTH-1:0] m_clip_start_y,
    output logic signed [COORD_WIDTH-1:0] m_clip_start_z,
    output logic signed [COORD_WIDTH-1:0] m_clip_start_w,
    output logic signed [COORD_WIDTH-1:0] m_clip_end_x,
    output logic signed [COORD_WIDTH-1:0] m_clip_end_y,
    output logic signed [COORD_WIDTH-1:0] m_clip_end_z,
    output logic signed [COORD_WIDTH-1:0] m_clip_end_w
);
    localparam int W  = COORD_WIDTH;
    localparam int CB = hlc_pkg::N_COORDS * COORD_WIDTH;
    // coordinates, six numerators, six denominators, class
    localparam int DW = CB + 2 * hlc_pkg::N_PLANES * (COORD_WIDTH + 2) + 2;

    logic [CB-1:0] in_coords;
    logic [CB-1:0] out_coords;
    hlc_pkg::hs_t  push_hs;
    logic          push_ready;
    logic [DW-1:0] push_data;
    logic          pop_valid, pop_ready;
    logic [DW-1:0] pop_data;

    // pack start vertex first, then end vertex, x to w
    assign in_coords = {s_end_w, s_end_z, s_end_y, s_end_x,
                        s_start_w, s_start_z, s_start_y, s_start_x};

    hlc_front #(.COORD_WIDTH(COORD_WIDTH), .DATA_WIDTH(DW)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_coords   (in_coords),
        .in_start_oc (s_start_outcode),
        .in_end_oc   (s_end_outcode),
        .push_hs_o   (push_hs),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    hlc_queue #(.DATA_WIDTH(DW)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_hs_i  (push_hs),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    hlc_back #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS),
               .DATA_WIDTH(DW)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (pop_valid),
        .in_ready    (pop_ready),
        .in_data     (pop_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_visible   (m_visible),
        .m_unclipped (m_unclipped),
        .m_enter_t   (m_enter_t),
        .m_exit_t    (m_exit_t),
        .m_coords    (out_coords)
    );

    // unpack the clipped endpoints
    assign m_clip_start_x = $signed(out_coords[0*W +: W]);
    assign m_clip_start_y = $signed(out_coords[1*W +: W]);
    assign m_clip_start_z = $signed(out_coords[2*W +: W]);
    assign m_clip_start_w = $signed(out_coords[3*W +: W]);
    assign m_clip_end_x   = $signed(out_coords[4*W +: W]);
    assign m_clip_end_y   = $signed(out_coords[5*W +: W]);
    assign m_clip_end_z   = $signed(out_coords[6*W +: W]);
    assign m_clip_end_w   = $signed(out_coords[7*W +: W]);
endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the homogeneous line clipper: directed and random segments.
`timescale 1ns / 1ps

module tb_top;

    localparam int CW = 32;
    localparam int TF = 16;
    localparam longint T_ONE = 64'sd1 << TF;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam int N_RANDOM = 1200;

    // outside code bits
    localparam logic [5:0] OC_XMIN = 6'b000001;
    localparam logic [5:0] OC_XMAX = 6'b000010;
    localparam logic [5:0] OC_YMIN = 6'b000100;
    localparam logic [5:0] OC_YMAX = 6'b001000;
    localparam logic [5:0] OC_ZMIN = 6'b010000;
    localparam logic [5:0] OC_ZMAX = 6'b100000;

    typedef struct {
        logic [3:0][CW-1:0] p0;     // start x, y, z, w
        logic [3:0][CW-1:0] p1;     // end x, y, z, w
        logic [5:0]         oc0;
        logic [5:0]         oc1;
    } segment_t;

    typedef struct {
        logic               visible;
        logic               unclipped;
        logic [TF:0]        enter_t;
        logic [TF:0]        exit_t;
        logic [3:0][CW-1:0] c0;
        logic [3:0][CW-1:0] c1;
    } clip_result_t;

    typedef struct {
        segment_t     seg;
        bit           typed;
        clip_result_t res;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CW-1:0] s_start_x = '0, s_start_y = '0, s_start_z = '0, s_start_w = '0;
    logic signed [CW-1:0] s_end_x = '0, s_end_y = '0, s_end_z = '0, s_end_w = '0;
    logic [5:0] s_start_outcode = '0, s_end_outcode = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_visible, m_unclipped;
    logic [TF:0] m_enter_t, m_exit_t;
    logic signed [CW-1:0] m_clip_start_x, m_clip_start_y, m_clip_start_z, m_clip_start_w;
    logic signed [CW-1:0] m_clip_end_x, m_clip_end_y, m_clip_end_z, m_clip_end_w;

    homogeneous_line_clipper_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_x(s_start_x), .s_start_y(s_start_y),
        .s_start_z(s_start_z), .s_start_w(s_start_w),
        .s_end_x(s_end_x), .s_end_y(s_end_y), .s_end_z(s_end_z), .s_end_w(s_end_w),
        .s_start_outcode(s_start_outcode), .s_end_outcode(s_end_outcode),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_visible(m_visible), .m_unclipped(m_unclipped),
        .m_enter_t(m_enter_t), .m_exit_t(m_exit_t),
        .m_clip_start_x(m_clip_start_x), .m_clip_start_y(m_clip_start_y),
        .m_clip_start_z(m_clip_start_z), .m_clip_start_w(m_clip_start_w),
        .m_clip_end_x(m_clip_end_x), .m_clip_end_y(m_clip_end_y),
        .m_clip_end_z(m_clip_end_z), .m_clip_end_w(m_clip_end_w)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    clip_result_t expected_clips[$];
    longint cycle_count = 0;
    int     error_count = 0;
    int     n_accept = 0, n_reject = 0, n_clipped = 0, n_received = 0;
    bit     idling_on = 1'b1;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // floor(num/den) in Q.TF, magnitude saturated to 2.0; den is non-zero
    function automatic longint plane_quotient(longint num, longint den);
        bit neg, inexact;
        longint unsigned n, d, ip, r, f, mag;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        ip = n / d;
        r = n % d;
        f = 0;
        if (ip >= 2) begin
            mag = 2 * T_ONE;
            inexact = 1'b0;
        end else begin
            for (int i = 0; i < TF; i++) begin
                r = r << 1;
                f = f << 1;
                if (r >= d) begin
                    r = r - d;
                    f = f | 1;
                end
            end
            mag = ip * T_ONE + f;
            inexact = (r != 0);
        end
        if (neg)
            return -longint'(mag) - (inexact ? 1 : 0);
        return longint'(mag);
    endfunction

    // narrow the parameter window against one plane; 0 means clipped away
    function automatic bit narrow_window(longint den, longint num,
                                         inout longint t_in, inout longint t_out);
        longint t;
        if (den > 0) begin
            t = plane_quotient(num, den);
            if (t > t_out) return 1'b0;
            if (t > t_in) t_in = t;
        end else if (den < 0) begin
            t = plane_quotient(num, den);
            if (t < t_in) return 1'b0;
            if (t < t_out) t_out = t;
        end else if (num > 0) begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // a + round((b - a) * t), ties away from zero on the magnitude
    function automatic logic [CW-1:0] interpolate(longint a, longint b, longint t);
        longint d;
        longint unsigned m, hi, lo, mag;
        d = b - a;
        m = (d < 0) ? -d : d;
        hi = m >> TF;
        lo = m & (T_ONE - 1);
        mag = hi * t + ((lo * t + (T_ONE >> 1)) >> TF);
        return (d < 0) ? CW'(a - longint'(mag)) : CW'(a + longint'(mag));
    endfunction

    function automatic clip_result_t predict_clip(segment_t seg);
        clip_result_t res;
        longint s[4], e[4], d[4];
        longint t_in, t_out;
        bit ok;
        res = '{default: '0};
        t_in = 0;
        t_out = T_ONE;
        ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            s[i] = longint'($signed(seg.p0[i]));
            e[i] = longint'($signed(seg.p1[i]));
            d[i] = e[i] - s[i];
        end
        if ((seg.oc0 | seg.oc1) == 6'd0) begin
            res.visible = 1'b1;
            res.unclipped = 1'b1;
            res.exit_t = (TF+1)'(T_ONE);
            res.c0 = seg.p0;
            res.c1 = seg.p1;
            return res;
        end
        if ((seg.oc0 & seg.oc1) != 6'd0)
            return res;
        // planes in order x-min, x-max, y-min, y-max, z-min, z-max
        for (int ax = 0; ax < 3 && ok; ax++) begin
            ok = narrow_window(d[ax] + d[3], -s[ax] - s[3], t_in, t_out);
            if (ok)
                ok = narrow_window(-d[ax] + d[3], s[ax] - s[3], t_in, t_out);
        end
        if (!ok)
            return res;
        if (t_in < 0) t_in = 0;
        if (t_out > T_ONE) t_out = T_ONE;
        res.visible = 1'b1;
        res.enter_t = (TF+1)'(t_in);
        res.exit_t = (TF+1)'(t_out);
        for (int i = 0; i < 4; i++) begin
            res.c0[i] = interpolate(s[i], e[i], t_in);
            res.c1[i] = interpolate(s[i], e[i], t_out);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus construction
    // ---------------------------------------------------------------

    function automatic segment_t make_segment(longint sx, longint sy, longint sz, longint sw,
                                              longint ex, longint ey, longint ez, longint ew,
                                              logic [5:0] oc0, logic [5:0] oc1);
        segment_t seg;
        seg.p0 = {CW'(sw), CW'(sz), CW'(sy), CW'(sx)};
        seg.p1 = {CW'(ew), CW'(ez), CW'(ey), CW'(ex)};
        seg.oc0 = oc0;
        seg.oc1 = oc1;
        return seg;
    endfunction

    function automatic logic [5:0] outside_code(logic [3:0][CW-1:0] p);
        logic [5:0] oc;
        longint w;
        w = longint'($signed(p[3]));
        oc = '0;
        for (int ax = 0; ax < 3; ax++) begin
            if (longint'($signed(p[ax])) < -w) oc = oc | (OC_XMIN << (2 * ax));
            if (longint'($signed(p[ax])) > w)  oc = oc | (OC_XMAX << (2 * ax));
        end
        return oc;
    endfunction

    // a coordinate within three times the given w either side
    function automatic longint near_volume(longint w);
        longint span;
        span = (w < 0) ? -w : w;
        return longint'($urandom_range(0, 6 * span)) - 3 * span;
    endfunction

    function automatic segment_t random_segment();
        segment_t seg;
        int mode;
        int still_ax;
        longint w0, w1;
        mode = $urandom_range(0, 9);
        if (mode == 7) begin
            // raw noise: every bit of every field at random
            for (int i = 0; i < 4; i++) begin
                seg.p0[i] = $urandom;
                seg.p1[i] = $urandom;
            end
            seg.oc0 = $urandom;
            seg.oc1 = $urandom;
            return seg;
        end
        w0 = longint'($urandom_range(1, 1 << $urandom_range(4, 22)));
        w1 = ($urandom_range(0, 3) == 0) ? w0 : longint'($urandom_range(1, 1 << 22));
        if (mode == 9) begin
            w0 = -w0;
            w1 = ($urandom_range(0, 1) == 0) ? -w1 : w1;
        end
        for (int i = 0; i < 3; i++) begin
            seg.p0[i] = CW'(near_volume(w0));
            seg.p1[i] = CW'(near_volume(w1));
        end
        seg.p0[3] = CW'(w0);
        seg.p1[3] = CW'(w1);
        // hold an axis still on both ends so its planes run parallel
        if ($urandom_range(0, 4) == 0) begin
            still_ax = $urandom_range(0, 2);
            seg.p1[3] = seg.p0[3];
            seg.p1[still_ax] = seg.p0[still_ax];
        end
        if (mode == 6) begin
            seg.oc0 = '0;
            seg.oc1 = '0;
        end else if (mode == 8) begin
            seg.oc0 = $urandom;
            seg.oc1 = $urandom & ~seg.oc0;
        end else begin
            seg.oc0 = outside_code(seg.p0);
            seg.oc1 = outside_code(seg.p1);
        end
        return seg;
    endfunction

    // ---------------------------------------------------------------
    // Driver
    // ---------------------------------------------------------------

    // called at a rising edge; returns at the edge on which the transfer happens
    task automatic send_segment(segment_t seg, clip_result_t res);
        int gap;
        gap = idling_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_start_x <= seg.p0[0];
        s_start_y <= seg.p0[1];
        s_start_z <= seg.p0[2];
        s_start_w <= seg.p0[3];
        s_end_x <= seg.p1[0];
        s_end_y <= seg.p1[1];
        s_end_z <= seg.p1[2];
        s_end_w <= seg.p1[3];
        s_start_outcode <= seg.oc0;
        s_end_outcode <= seg.oc1;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        expected_clips.push_back(res);
        if (res.unclipped) n_accept++;
        else if (res.visible) n_clipped++;
        else n_reject++;
    endtask

    stim_row_t directed[$];

    task automatic build_directed();
        stim_row_t row;
        clip_result_t none;
        longint one;
        one = T_ONE;
        none = '{default: '0};

        // trivial accept at both coordinate extremes, endpoints pass through
        row.seg = make_segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               -2147483648, -2147483648, -2147483648, -2147483648, 0, 0);
        row.typed = 1'b1;
        row.res = '{1'b1, 1'b1, '0, (TF+1)'(T_ONE), row.seg.p0, row.seg.p1};
        directed.push_back(row);
        row.seg = make_segment(0, 0, 0, 0, -1, -1, -1, -1, 0, 0);
        row.res = '{1'b1, 1'b1, '0, (TF+1)'(T_ONE), row.seg.p0, row.seg.p1};
        directed.push_back(row);

        // trivial reject on each shared outside bit, and all bits shared
        for (int b = 0; b < 6; b++) begin
            row.seg = make_segment(3 * one, -one, one / 2, one, 5 * one, 2, 7, one,
                                   6'd1 << b, 6'd1 << b);
            row.res = none;
            directed.push_back(row);
        end
        row.seg = make_segment(-1, -1, -1, -1, 32'h7fffffff, 0, 0, 1, 6'h3f, 6'h3f);
        row.res = none;
        directed.push_back(row);

        // the rest go through the predictor
        row.typed = 1'b0;
        // crosses x-max, then x-min, then y and z in turn
        directed.push_back('{make_segment(0, 0, 0, one, 2 * one, 0, 0, one,
                                          0, OC_XMAX), 1'b0, none});
        directed.push_back('{make_segment(-3 * one, one / 3, 0, one, one / 4, 0, 0, one,
                                          OC_XMIN, 0), 1'b0, none});
        directed.push_back('{make_segment(0, -5 * one, one, 2 * one, one, 7 * one, -one, 2 * one,
                                          OC_YMIN, OC_YMAX), 1'b0, none});
        directed.push_back('{make_segment(one / 7, 0, -9 * one, one, -one / 5, one / 3, 9 * one,
                                          3 * one, OC_ZMIN, OC_ZMAX), 1'b0, none});
        // touches a corner: every plane passes alone, the window shrinks to one point
        directed.push_back('{make_segment(2 * one, 0, 0, one, 0, 2 * one, 0, one,
                                          OC_XMAX, OC_YMAX), 1'b0, none});
        // parallel plane with positive numerator: rejected
        directed.push_back('{make_segment(2 * one, 0, 0, one, 2 * one, one / 2, 0, one,
                                          OC_YMIN, 0), 1'b0, none});
        // parallel plane inside: kept, parameters unchanged
        directed.push_back('{make_segment(0, 0, 0, one, 0, 0, 3 * one, one,
                                          0, OC_ZMAX), 1'b0, none});
        // codes that do not match the coordinates are trusted as given
        directed.push_back('{make_segment(0, 0, 0, one, one / 2, 0, 0, one,
                                          OC_XMIN, OC_ZMAX), 1'b0, none});
        // coordinate extremes with disjoint codes: large numerators saturate
        directed.push_back('{make_segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                          -2147483648, -2147483648, -2147483648, -2147483648,
                                          OC_XMIN, OC_XMAX), 1'b0, none});
        directed.push_back('{make_segment(-2147483648, 32'h7fffffff, -2147483648, 1,
                                          32'h7fffffff, -2147483648, 32'h7fffffff, 32'h7fffffff,
                                          OC_XMIN | OC_YMAX, OC_XMAX | OC_YMIN), 1'b0, none});
        // negative w on both ends
        directed.push_back('{make_segment(one, 0, 0, -one, -one, 0, 0, -2 * one,
                                          OC_XMAX, OC_XMIN), 1'b0, none});
    endtask

    initial begin
        build_directed();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_segment(directed[i].seg,
                         directed[i].typed ? directed[i].res : predict_clip(directed[i].seg));

        for (int n = 0; n < N_RANDOM; n++) begin
            // alternate stretches with and without idling
            if (n % 200 == 0)
                idling_on <= ((n / 200) % 2 == 0);
            begin
                segment_t seg;
                seg = random_segment();
                send_segment(seg, predict_clip(seg));
            end
        end
        s_valid <= 1'b0;

        while (expected_clips.size() != 0)
            @(posedge aclk);
        repeat (140) @(posedge aclk);

        $display("Segments checked: %0d (trivially accepted %0d, clipped %0d, rejected %0d).",
                 n_received, n_accept, n_clipped, n_reject);
        $display("Directed extremes, parallel planes, odd codes and random clip-space segments.");
        if (error_count == 0 && expected_clips.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: random stalls, check each transfer against the oldest expectation
    // ---------------------------------------------------------------

    int stall_left = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_received++;
                if (expected_clips.size() == 0) begin
                    $error("result transfer with no segment outstanding");
                    error_count++;
                end else begin
                    clip_result_t exp_r;
                    exp_r = expected_clips.pop_front();
                    if (m_visible !== exp_r.visible) begin
                        $error("visible: expected %0d, got %0d", exp_r.visible, m_visible);
                        error_count++;
                    end
                    if (m_unclipped !== exp_r.unclipped) begin
                        $error("unclipped: expected %0d, got %0d", exp_r.unclipped, m_unclipped);
                        error_count++;
                    end
                    if (m_enter_t !== exp_r.enter_t) begin
                        $error("enter_t: expected %h, got %h", exp_r.enter_t, m_enter_t);
                        error_count++;
                    end
                    if (m_exit_t !== exp_r.exit_t) begin
                        $error("exit_t: expected %h, got %h", exp_r.exit_t, m_exit_t);
                        error_count++;
                    end
                    begin
                        logic [3:0][CW-1:0] got0, got1;
                        got0 = {m_clip_start_w, m_clip_start_z, m_clip_start_y, m_clip_start_x};
                        got1 = {m_clip_end_w, m_clip_end_z, m_clip_end_y, m_clip_end_x};
                        for (int i = 0; i < 4; i++) begin
                            if (got0[i] !== exp_r.c0[i]) begin
                                $error("clip_start_%s: expected %h, got %h",
                                       i == 0 ? "x" : i == 1 ? "y" : i == 2 ? "z" : "w",
                                       exp_r.c0[i], got0[i]);
                                error_count++;
                            end
                            if (got1[i] !== exp_r.c1[i]) begin
                                $error("clip_end_%s: expected %h, got %h",
                                       i == 0 ? "x" : i == 1 ? "y" : i == 2 ? "z" : "w",
                                       exp_r.c1[i], got1[i]);
                                error_count++;
                            end
                        end
                    end
                end
                // draw the stall before the next transfer
                stall_left = idling_on ? $urandom_range(0, 6) : 0;
                if (stall_left > 0)
                    m_ready <= 1'b0;
            end else if (!m_ready) begin
                if (stall_left > 0)
                    stall_left--;
                if (stall_left == 0)
                    m_ready <= 1'b1;
            end
        end
    end

    // hard stop if the block hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding.",
                     cycle_count, expected_clips.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

@@ files.f @@
src/hlc_pkg.sv
src/hlc_front.sv
src/hlc_queue.sv
src/hlc_back.sv
src/homogeneous_line_clipper_unit.sv
test/tb_top.sv
